### sv/hcbp_pkg.sv
// Package for the Huffman code bit packer: transfer structs, request codes,
// table entry type and derived widths. No dependencies.
package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;

    // code length that can actually be stored: also bounded by the code field
    localparam int EFF_LEN = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
    // 7 pending bits plus one code
    localparam int ACC_W   = EFF_LEN + 7;
    localparam int TOT_W   = $clog2(ACC_W + 1);
    localparam int SYM_AW  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    typedef enum logic [1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req_type;

    typedef struct packed {
        t_req_type   req_type;
        logic [7:0]  symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_len;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [5:0]  len;
        logic [31:0] code;
    } t_entry;

    // table access from the packer
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [SYM_AW-1:0] addr;
        t_entry            wr_entry;
    } t_tbl_req;

endpackage

### sv/hcbp_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/hcbp_code_table.sv
// Code table: one RAM holding length and code per symbol, plus per-entry
// valid flags so that unwritten entries read as length zero.
// Depends on hcbp_pkg and hcbp_ram.
module hcbp_code_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hcbp_pkg::t_tbl_req i_req,
    output hcbp_pkg::t_entry  o_entry
);
    import hcbp_pkg::*;

    localparam int ENTRY_W = $bits(t_entry);
    localparam int RAM_DEPTH = 1 << SYM_AW;

    logic [SYMBOL_COUNT-1:0] r_valid;
    logic                    r_rd_valid;
    logic [ENTRY_W-1:0]      ram_rdata;
    t_entry                  ram_entry;

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr_en),
        .i_re    (i_req.rd_en),
        .i_addr  (i_req.addr),
        .i_wdata (i_req.wr_entry),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.addr];
            end
        end
    end

    assign ram_entry = t_entry'(ram_rdata);

    always_comb begin
        o_entry      = ram_entry;
        o_entry.len  = r_rd_valid ? ram_entry.len : 6'd0;
    end

endmodule

### sv/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer: request sequencer and byte packer.
// Depends on hcbp_pkg and hcbp_code_table.
//
//   channel | direction | valid       | stall       | payload
//   input   | in        | i_in_valid  | o_in_stall  | i_in  (t_in_item)
//   output  | out       | o_out_valid | i_out_stall | o_out (t_out_item)
//
// Load: table write. Encode: table read in S_LOOKUP, then one output byte per
// cycle (up to 4) while the output register is free, or a pass through S_EMIT
// keeping only the pending bits if no byte completes. Flush: the padded byte
// goes out through S_EMIT. Reset is synchronous and clears the table valid
// flags and the pending bits. An output stall holds the byte loop until the
// output register frees; the next item is taken while the last byte waits.
module huffman_code_bit_packer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hcbp_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hcbp_pkg::t_out_item o_out
);
    import hcbp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_EMIT
    } t_state;

    localparam logic [8:0]       SYM_LIMIT = 9'(SYMBOL_COUNT);
    localparam logic [5:0]       LEN_LIMIT = 6'(EFF_LEN);
    localparam logic [TOT_W-1:0] BYTE_BITS = TOT_W'(8);

    t_state           r_state;
    logic             r_out_valid;
    t_out_item        r_out;
    logic [6:0]       r_pend_bits;
    logic [2:0]       r_pend_cnt;
    logic [ACC_W-1:0] r_acc;
    logic [TOT_W-1:0] r_total;

    logic             accept;
    logic             sym_ok;
    logic             out_free;
    logic             load_byte;
    logic [5:0]       load_len;
    logic [31:0]      load_mask;
    t_tbl_req         tbl_req;
    t_entry           tbl_entry;
    logic [ACC_W-1:0] acc_new;
    logic [TOT_W-1:0] total_new;
    logic [TOT_W-1:0] total_rem;
    logic [ACC_W-1:0] acc_shifted;
    logic [6:0]       keep_mask;
    logic [7:0]       flush_byte;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign sym_ok    = {1'b0, i_in.symbol} < SYM_LIMIT;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign load_byte = (r_state == S_EMIT) && (r_total >= BYTE_BITS) && out_free;

    assign load_len  = (i_in.code_len > LEN_LIMIT) ? LEN_LIMIT : i_in.code_len;
    assign load_mask = ~({32{1'b1}} << load_len);

    always_comb begin
        tbl_req.wr_en         = accept && (i_in.req_type == REQ_LOAD) && sym_ok;
        tbl_req.rd_en         = accept && (i_in.req_type == REQ_ENCODE) && sym_ok;
        tbl_req.addr          = i_in.symbol[SYM_AW-1:0];
        tbl_req.wr_entry.len  = load_len;
        tbl_req.wr_entry.code = i_in.code_bits & load_mask;
    end

    hcbp_code_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_entry (tbl_entry)
    );

    // stored codes are already masked to their length
    assign acc_new     = (ACC_W'(r_pend_bits) << tbl_entry.len) | ACC_W'(tbl_entry.code);
    assign total_new   = TOT_W'(r_pend_cnt) + TOT_W'(tbl_entry.len);
    assign total_rem   = r_total - BYTE_BITS;
    assign acc_shifted = r_acc >> total_rem;
    // leftover bits keep the same low three bits of the count
    assign keep_mask   = ~(7'h7f << r_total[2:0]);
    assign flush_byte  = 8'({1'b0, r_pend_bits} << (4'd8 - {1'b0, r_pend_cnt}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
        end else begin
            if (load_byte) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_in.req_type)
                            REQ_ENCODE: begin
                                if (sym_ok) begin
                                    r_state <= S_LOOKUP;
                                end
                            end
                            REQ_FLUSH: begin
                                if (r_pend_cnt != 3'd0) begin
                                    r_acc   <= ACC_W'(flush_byte);
                                    r_total <= BYTE_BITS;
                                    r_state <= S_EMIT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LOOKUP: begin
                    if (tbl_entry.len == 6'd0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_acc   <= acc_new;
                        r_total <= total_new;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_total < BYTE_BITS) begin
                        r_pend_cnt  <= r_total[2:0];
                        r_pend_bits <= r_acc[6:0] & keep_mask;
                        r_state     <= S_IDLE;
                    end else if (out_free) begin
                        r_out.out_byte <= acc_shifted[7:0];
                        r_out.last     <= total_rem < BYTE_BITS;
                        r_total        <= total_rem;
                        if (total_rem < BYTE_BITS) begin
                            r_pend_cnt  <= r_total[2:0];
                            r_pend_bits <= r_acc[6:0] & keep_mask;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // pending bits above the pending count stay zero
    a_pend_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_bits & ~(~(7'h7f << r_pend_cnt))) == 7'd0)
        else $error("pending bits set beyond pending count");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_total <= TOT_W'(ACC_W)))
        else $error("bit count exceeds accumulator width");

    a_lookup_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP) |-> ($past(r_state) == S_IDLE))
        else $error("table lookup entered outside idle");

    a_byte_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("output byte loaded outside emit state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && r_state == S_EMIT && r_total >= BYTE_BITS)
        |=> (r_total == $past(r_total)))
        else $error("byte loop advanced while output register full");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Testbench for huffman_code_bit_packer: a directed table, then random loads,
// encodes and flushes, each output byte checked against typed bytes or an inline bit packer.
// Depends on hcbp_pkg and the packer RTL.
module tb;
    import hcbp_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'b11;
    localparam int IDLE_LIMIT   = 1000;
    localparam int RAND_ITEMS   = 146;
    localparam int DRAIN_CYCLES = 50;
    localparam int NO_TYPED     = -1;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in        = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;

    huffman_code_bit_packer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // directed row: bytes typed MSB first in typed_bytes, or NO_TYPED
    typedef struct {
        t_in_item    item;
        int          n_typed;
        logic [31:0] typed_bytes;
    } t_row;

    t_row        dir_rows[$];
    logic [31:0] code_tbl [SYMBOL_COUNT];
    logic [5:0]  len_tbl [SYMBOL_COUNT];
    bit          was_loaded [SYMBOL_COUNT];
    logic [7:0]  loaded_syms[$];
    logic [6:0]  pend_bits = '0;
    int unsigned pend_cnt  = 0;
    t_out_item   packed_bytes[$];
    t_out_item   bytes_due[$];
    int          errors      = 0;
    int          idle_cycles = 0;
    bit          calm        = 1'b0;

    function automatic t_in_item mk_item(logic [1:0] req, logic [7:0] sym,
                                         logic [31:0] code, logic [5:0] len);
        t_in_item it;
        it.req_type  = t_req_type'(req);
        it.symbol    = sym;
        it.code_bits = code;
        it.code_len  = len;
        return it;
    endfunction

    function automatic void add_row(logic [1:0] req, logic [7:0] sym, logic [31:0] code,
                                    logic [5:0] len, int n_typed, logic [31:0] typed);
        t_row r;
        r.item        = mk_item(req, sym, code, len);
        r.n_typed     = n_typed;
        r.typed_bytes = typed;
        dir_rows.push_back(r);
    endfunction

    // bit packer: updates table and accumulator, leaves bytes in packed_bytes
    function automatic void pack_item(t_in_item it);
        int unsigned len;
        int unsigned total;
        logic [63:0] acc;
        t_out_item   r;
        packed_bytes.delete();
        case (it.req_type)
            REQ_LOAD: begin
                if (it.symbol < SYMBOL_COUNT) begin
                    len = it.code_len;
                    if (len > EFF_LEN) len = EFF_LEN;
                    len_tbl[it.symbol]  = 6'(len);
                    code_tbl[it.symbol] = 32'(64'(it.code_bits) & ((64'd1 << len) - 64'd1));
                    if (!was_loaded[it.symbol]) begin
                        was_loaded[it.symbol] = 1'b1;
                        loaded_syms.push_back(it.symbol);
                    end
                end
            end
            REQ_ENCODE: begin
                if (it.symbol < SYMBOL_COUNT && len_tbl[it.symbol] != 0) begin
                    len   = len_tbl[it.symbol];
                    acc   = (64'(pend_bits) << len) | 64'(code_tbl[it.symbol]);
                    total = pend_cnt + len;
                    while (total >= 8) begin
                        total      -= 8;
                        r.out_byte = 8'(acc >> total);
                        r.last     = (total < 8);
                        packed_bytes.push_back(r);
                    end
                    pend_cnt  = total;
                    pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
                end
            end
            REQ_FLUSH: begin
                if (pend_cnt != 0) begin
                    r.out_byte = 8'({1'b0, pend_bits} << (8 - pend_cnt));
                    r.last     = 1'b1;
                    packed_bytes.push_back(r);
                    pend_bits = '0;
                    pend_cnt  = 0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item    it;
        int unsigned pick;
        int unsigned lsel;
        it.req_type  = REQ_LOAD;
        it.symbol    = 8'($urandom_range(0, 255));
        it.code_bits = $urandom;
        it.code_len  = 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            lsel = $urandom_range(0, 99);
            if (lsel < 5)       it.code_len = '0;
            else if (lsel < 70) it.code_len = 6'($urandom_range(1, 10));
            else if (lsel < 90) it.code_len = 6'($urandom_range(11, 32));
            else                it.code_len = 6'($urandom_range(33, 63));
            // half the loads rewrite an entry already in use
            if ($urandom_range(0, 1) == 0)
                it.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        end else if (pick < 80) begin
            it.req_type = REQ_ENCODE;
            it.symbol   = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        end else if (pick < 94) begin
            it.req_type = REQ_FLUSH;
        end else begin
            it.req_type = t_req_type'(REQ_UNUSED);
        end
        return it;
    endfunction

    function automatic void note_error(string msg);
        errors++;
        if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function automatic void check_byte(t_out_item got);
        t_out_item want;
        if (bytes_due.size() == 0) begin
            note_error($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last));
        end else begin
            want = bytes_due.pop_front();
            if (got.out_byte !== want.out_byte || got.last !== want.last)
                note_error($sformatf("byte exp %02h last %0b, got %02h last %0b",
                                     want.out_byte, want.last, got.out_byte, got.last));
        end
    endfunction

    task automatic send_item(input t_in_item it, input int n_typed, input logic [31:0] typed);
        int        gap;
        t_out_item r;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pack_item(it);
        if (n_typed == NO_TYPED) begin
            foreach (packed_bytes[j]) bytes_due.push_back(packed_bytes[j]);
        end else begin
            for (int j = 0; j < n_typed; j++) begin
                r.out_byte = typed[31 - 8 * j -: 8];
                r.last     = (j == n_typed - 1);
                bytes_due.push_back(r);
            end
        end
    endtask

    // output side: random stall after each transfer
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                check_byte(o_out);
                hold = calm ? 0 : $urandom_range(0, 5);
            end else if (hold > 0) begin
                hold--;
            end
            i_out_stall <= (hold > 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int s = 0; s < SYMBOL_COUNT; s++) begin
            code_tbl[s]   = '0;
            len_tbl[s]    = '0;
            was_loaded[s] = 1'b0;
        end
        add_row(REQ_FLUSH,  8'd0,   32'h0,        6'd0,  0, 32'h0);        // empty flush
        add_row(REQ_UNUSED, 8'd255, 32'hFFFFFFFF, 6'd63, 0, 32'h0);
        add_row(REQ_LOAD,   8'd0,   32'hFFFFFFFF, 6'd32, 0, 32'h0);
        add_row(REQ_ENCODE, 8'd0,   32'h0,        6'd0,  4, 32'hFFFFFFFF);
        add_row(REQ_LOAD,   8'd255, 32'h1,        6'd1,  0, 32'h0);
        add_row(REQ_ENCODE, 8'd255, 32'h0,        6'd0,  0, 32'h0);
        add_row(REQ_FLUSH,  8'd0,   32'h0,        6'd0,  1, 32'h80000000);
        // overlong length saturates to 32
        add_row(REQ_LOAD,   8'd1,   32'hFFFFFFFF, 6'd63, 0, 32'h0);
        add_row(REQ_ENCODE, 8'd1,   32'h0,        6'd0,  4, 32'hFFFFFFFF);
        // code bits above the length are dropped
        add_row(REQ_LOAD,   8'd2,   32'hFFFFFFFF, 6'd3,  0, 32'h0);
        add_row(REQ_ENCODE, 8'd2,   32'h0,        6'd0,  0, 32'h0);
        add_row(REQ_ENCODE, 8'd2,   32'h0,        6'd0,  0, 32'h0);
        add_row(REQ_ENCODE, 8'd2,   32'h0,        6'd0,  1, 32'hFF000000);
        add_row(REQ_FLUSH,  8'd0,   32'h0,        6'd0,  1, 32'h80000000);
        // absent symbol
        add_row(REQ_LOAD,   8'd3,   32'h0000ABCD, 6'd0,  0, 32'h0);
        add_row(REQ_ENCODE, 8'd3,   32'h0,        6'd0,  0, 32'h0);
        // seven pending bits plus a 32-bit code
        add_row(REQ_LOAD,   8'd4,   32'h0,        6'd7,  0, 32'h0);
        add_row(REQ_ENCODE, 8'd4,   32'h0,        6'd0,  NO_TYPED, 32'h0);
        add_row(REQ_ENCODE, 8'd0,   32'h0,        6'd0,  NO_TYPED, 32'h0);
        add_row(REQ_FLUSH,  8'd0,   32'h0,        6'd0,  NO_TYPED, 32'h0);
        add_row(REQ_LOAD,   8'd128, 32'h80000000, 6'd32, 0, 32'h0);
        add_row(REQ_ENCODE, 8'd128, 32'h0,        6'd0,  NO_TYPED, 32'h0);
        add_row(REQ_FLUSH,  8'd0,   32'h0,        6'd0,  0, 32'h0);
        add_row(REQ_UNUSED, 8'd0,   32'h0,        6'd33, 0, 32'h0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[k])
            send_item(dir_rows[k].item, dir_rows[k].n_typed, dir_rows[k].typed_bytes);
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k % 30 == 0) calm = ($urandom_range(0, 2) == 0);
            send_item(rand_item(), NO_TYPED, 32'h0);
        end
        i_in_valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
